[rtl/srs_pkg.sv]
package srs_pkg;

   // item modes
   localparam logic [1:0] MODE_RX     = 2'd0;
   localparam logic [1:0] MODE_GAP    = 2'd1;
   localparam logic [1:0] MODE_SENSOR = 2'd2;
   localparam logic [1:0] MODE_TX     = 2'd3;

   // frame bytes and function codes
   localparam logic [7:0] HEADER_BYTE    = 8'hAA;
   localparam logic [7:0] SLAVE_ID_BYTE  = 8'h01;
   localparam logic [7:0] FN_READ        = 8'h05;
   localparam logic [7:0] FN_READ_REPLY  = 8'h06;
   localparam logic [7:0] FN_WRITE       = 8'h07;
   localparam logic [7:0] FN_WRITE_REPLY = 8'h08;
   localparam logic [7:0] WRITE_LIMIT    = 8'h10;
   localparam logic [7:0] HUNT_LIMIT     = 8'd250;

   // crc-16/modbus, reflected
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // one input beat
   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data;
      logic [7:0] reg_addr;
   } item_type;

   // request decoded at a frame gap
   typedef struct packed {
      logic       queue_read;
      logic       queue_write;
      logic [7:0] reg_index;
      logic [7:0] count;
   } req_event_type;

   // one byte through the crc, lsb first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[rtl/serial_register_slave_crc16.sv]
// Serial register slave with a CRC-16/Modbus reply path.
// req channel: one beat per event. req_mode 0 is a received byte (req_data),
// 1 a frame gap, 2 a sensor write of req_data to register req_reg_addr,
// 3 a transmit slot. A frame gap evaluates the parsed request and may queue a
// read reply (AA,01,06,len,data..,crc lo,crc hi) or a write reply
// (AA,01,08,reg,data,crc lo,crc hi); a new reply replaces a pending one.
// rsp channel: each transmit slot with a reply pending yields one beat
// (rsp_tx_byte, rsp_last high on the final crc byte); idle slots yield none.
// csr channel: writes device_address; always ready, write it only when idle.
// Timing: a req beat lands in an input register, is processed from there
// through the parser, reply sequencer and register file, and its rsp beat
// is held in an output register. One beat per cycle is sustained while
// rsp_ready keeps up; the register file read port is read every cycle at
// the reply pointer.
// Reset (synchronous) clears all control state, device_address and the
// register file written flags, so every register reads as zero.
// When rsp_ready is low with a beat waiting, one more req beat is taken into
// the input register and then req_ready drops until the rsp beat goes.
module serial_register_slave_crc16 #(
   parameter int REG_COUNT = 200
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_data,
   input  logic [7:0] req_reg_addr,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic                   in_valid_ff;
   srs_pkg::item_type      item_ff;
   logic [7:0]             device_address_ff;
   logic                   advance;
   logic                   fire;
   logic                   tx_fire;
   logic                   sensor_wr;
   srs_pkg::req_event_type req_event;
   logic                   wr_en;
   logic [7:0]             wr_addr;
   logic [7:0]             wr_data;
   logic [7:0]             rd_addr;
   logic [7:0]             rd_data;

   // handshake
   assign advance   = !rsp_valid || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign tx_fire   = fire && (item_ff.mode == srs_pkg::MODE_TX);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.mode     <= req_mode;
         item_ff.data     <= req_data;
         item_ff.reg_addr <= req_reg_addr;
      end
   end

   // device address register
   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= 8'h00;
      end else if (csr_valid && csr_ready) begin
         device_address_ff <= csr_data;
      end
   end

   // register file write select: sensor beat or accepted write request
   assign sensor_wr = fire && (item_ff.mode == srs_pkg::MODE_SENSOR) &&
                      (item_ff.reg_addr < 8'(REG_COUNT));
   assign wr_en     = sensor_wr || req_event.queue_write;
   assign wr_addr   = req_event.queue_write ? req_event.reg_index : item_ff.reg_addr;
   assign wr_data   = req_event.queue_write ? req_event.count : item_ff.data;

   srs_parser #(
      .REG_COUNT(REG_COUNT)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .item          (item_ff),
      .device_address(device_address_ff),
      .req_event     (req_event)
   );

   srs_regfile #(
      .REG_COUNT(REG_COUNT)
   ) u_regfile (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   srs_reply u_reply (
      .clock      (clock),
      .reset      (reset),
      .tx_fire    (tx_fire),
      .req_event  (req_event),
      .rd_data    (rd_data),
      .rsp_ready  (rsp_ready),
      .rd_addr    (rd_addr),
      .rsp_valid  (rsp_valid),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_last   (rsp_last)
   );

endmodule

[rtl/srs_regfile.sv]
module srs_regfile #(
   parameter int REG_COUNT = 200
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  logic [7:0] wr_addr,
   input  logic [7:0] wr_data,
   input  logic [7:0] rd_addr,
   output logic [7:0] rd_data
);

   localparam int AW = $clog2(REG_COUNT);

   logic [7:0]           mem_ff [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [7:0]           rd_mem_ff;
   logic                 rd_ok_ff;
   logic                 rd_ok_in;
   logic                 rd_hit_ff;
   logic                 rd_hit_in;
   logic [7:0]           hit_data_ff;
   logic [AW-1:0]        wr_index;
   logic [AW-1:0]        rd_index;
   logic                 rd_in_range;

   assign wr_index    = wr_addr[AW-1:0];
   assign rd_index    = rd_addr[AW-1:0];
   assign rd_in_range = rd_addr < 8'(REG_COUNT);

   // forward a same-cycle write; entries never written read as zero
   always_comb begin
      rd_hit_in = wr_en && (wr_addr == rd_addr) && rd_in_range;
      rd_ok_in  = rd_in_range && (valid_ff[rd_index] || rd_hit_in);
   end

   // storage array with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_index] <= wr_data;
      end
      rd_mem_ff   <= mem_ff[rd_index];
      hit_data_ff <= wr_data;
   end

   // written flags and read qualifiers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_ok_ff  <= 1'b0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_index] <= 1'b1;
         end
         rd_ok_ff  <= rd_ok_in;
         rd_hit_ff <= rd_hit_in;
      end
   end

   assign rd_data = !rd_ok_ff ? 8'h00 : (rd_hit_ff ? hit_data_ff : rd_mem_ff);

endmodule

[rtl/srs_parser.sv]
module srs_parser #(
   parameter int REG_COUNT = 200
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  srs_pkg::item_type      item,
   input  logic [7:0]             device_address,
   output srs_pkg::req_event_type req_event
);

   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_ADDR = 3'd1;
   localparam logic [2:0] PH_FUNC = 3'd2;
   localparam logic [2:0] PH_REG  = 3'd3;
   localparam logic [2:0] PH_CNT  = 3'd4;
   localparam logic [2:0] PH_DONE = 3'd5;
   localparam logic [2:0] PH_SKIP = 3'd6;

   logic [2:0] phase_ff, phase_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] func_ff, func_in;
   logic [7:0] reg_ff, reg_in;
   logic [7:0] cnt_ff, cnt_in;
   logic       gap_fire;
   logic       gap_ok;
   logic [8:0] read_end;

   assign gap_fire = fire && (item.mode == srs_pkg::MODE_GAP);
   assign gap_ok   = (phase_ff >= PH_FUNC) && (phase_ff <= PH_DONE);
   assign read_end = {1'b0, reg_ff} + {1'b0, cnt_ff};

   // request decode at the frame gap
   always_comb begin
      req_event.queue_read  = gap_fire && gap_ok && (func_ff == srs_pkg::FN_READ) &&
                              (read_end <= 9'(REG_COUNT));
      req_event.queue_write = gap_fire && gap_ok && (func_ff == srs_pkg::FN_WRITE) &&
                              (reg_ff <= srs_pkg::WRITE_LIMIT);
      req_event.reg_index   = reg_ff;
      req_event.count       = cnt_ff;
   end

   // frame parser
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      func_in  = func_ff;
      reg_in   = reg_ff;
      cnt_in   = cnt_ff;
      if (gap_fire) begin
         phase_in = PH_HUNT;
         pos_in   = 8'h00;
         func_in  = 8'h00;
         reg_in   = 8'h00;
         cnt_in   = 8'h00;
      end else if (fire && (item.mode == srs_pkg::MODE_RX)) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if ((pos_ff < srs_pkg::HUNT_LIMIT) && (item.data == srs_pkg::HEADER_BYTE)) begin
                  phase_in = PH_ADDR;
               end
            end
            PH_ADDR: begin
               phase_in = (item.data == device_address) ? PH_FUNC : PH_SKIP;
            end
            PH_FUNC: begin
               func_in  = item.data;
               phase_in = PH_REG;
            end
            PH_REG: begin
               reg_in   = item.data;
               phase_in = PH_CNT;
            end
            PH_CNT: begin
               cnt_in   = item.data;
               phase_in = PH_DONE;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         if (pos_ff != 8'hFF) begin
            pos_in = pos_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= 8'h00;
         func_ff  <= 8'h00;
         reg_ff   <= 8'h00;
         cnt_ff   <= 8'h00;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         func_ff  <= func_in;
         reg_ff   <= reg_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[rtl/srs_reply.sv]
module srs_reply (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tx_fire,
   input  srs_pkg::req_event_type req_event,
   input  logic [7:0]             rd_data,
   input  logic                   rsp_ready,
   output logic [7:0]             rd_addr,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_tx_byte,
   output logic                   rsp_last
);

   localparam logic [1:0] RK_NONE  = 2'd0;
   localparam logic [1:0] RK_READ  = 2'd1;
   localparam logic [1:0] RK_WRITE = 2'd2;
   localparam logic [1:0] RK_CRC   = 2'd3;

   logic [1:0]  kind_ff, kind_in;
   logic [2:0]  index_ff, index_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  rreg_ff, rreg_in;
   logic [7:0]  left_ff, left_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_tx_byte_ff;
   logic        rsp_last_ff;
   logic        emit;
   logic [7:0]  tx_byte;
   logic        tx_last;

   assign emit = tx_fire && (kind_ff != RK_NONE);

   // reply sequencer
   always_comb begin
      kind_in  = kind_ff;
      index_in = index_ff;
      crc_in   = crc_ff;
      rreg_in  = rreg_ff;
      left_in  = left_ff;
      tx_byte  = 8'h00;
      tx_last  = 1'b0;
      if (req_event.queue_read || req_event.queue_write) begin
         kind_in  = req_event.queue_read ? RK_READ : RK_WRITE;
         index_in = 3'd0;
         crc_in   = srs_pkg::CRC_INIT;
         rreg_in  = req_event.reg_index;
         left_in  = req_event.count;
      end else if (emit) begin
         if (kind_ff == RK_CRC) begin
            if (index_ff == 3'd0) begin
               tx_byte  = crc_ff[7:0];
               index_in = 3'd1;
            end else begin
               tx_byte  = crc_ff[15:8];
               tx_last  = 1'b1;
               kind_in  = RK_NONE;
               index_in = 3'd0;
            end
         end else begin
            case (index_ff)
               3'd0: tx_byte = srs_pkg::HEADER_BYTE;
               3'd1: tx_byte = srs_pkg::SLAVE_ID_BYTE;
               3'd2: tx_byte = (kind_ff == RK_READ) ? srs_pkg::FN_READ_REPLY
                                                    : srs_pkg::FN_WRITE_REPLY;
               3'd3: tx_byte = (kind_ff == RK_READ) ? left_ff : rreg_ff;
               default: begin
                  tx_byte = rd_data;
                  if (kind_ff == RK_READ) begin
                     rreg_in = rreg_ff + 8'd1;
                     left_in = left_ff - 8'd1;
                  end
               end
            endcase
            crc_in = srs_pkg::crc16_byte(crc_ff, tx_byte);
            if (index_ff < 3'd4) begin
               index_in = index_ff + 3'd1;
            end
            // read ends after its last data beat (after the len byte when the count is zero), write after its data beat
            if ((kind_ff == RK_READ) && (index_ff >= 3'd3) && (left_in == 8'h00)) begin
               kind_in  = RK_CRC;
               index_in = 3'd0;
            end
            if ((kind_ff == RK_WRITE) && (index_ff == 3'd4)) begin
               kind_in  = RK_CRC;
               index_in = 3'd0;
            end
         end
      end
   end

   // output register
   assign rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= RK_NONE;
         index_ff     <= 3'd0;
         crc_ff       <= srs_pkg::CRC_INIT;
         rreg_ff      <= 8'h00;
         left_ff      <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         kind_ff      <= kind_in;
         index_ff     <= index_in;
         crc_ff       <= crc_in;
         rreg_ff      <= rreg_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_tx_byte_ff <= tx_byte;
         rsp_last_ff    <= tx_last;
      end
   end

   assign rd_addr     = rreg_in;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tx_byte = rsp_tx_byte_ff;
   assign rsp_last    = rsp_last_ff;

   // sequencer checks
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      index_ff <= 3'd4)
      else $error("reply index out of range");

   a_crc_index: assert property (@(posedge clock) disable iff (reset)
      (kind_ff == RK_CRC) |-> (index_ff <= 3'd1))
      else $error("crc phase index out of range");

   a_read_left: assert property (@(posedge clock) disable iff (reset)
      ((kind_ff == RK_READ) && (index_ff == 3'd4)) |-> (left_ff != 8'h00))
      else $error("read reply in data phase with nothing left");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (emit && tx_last && !req_event.queue_read && !req_event.queue_write)
         |=> (kind_ff == RK_NONE))
      else $error("reply still pending after its last beat");

endmodule
